@@ hw/rtl/tpta_pkg.sv @@
// Shared types and constants for the tag presence table with aging.
`timescale 1ns / 1ps
`default_nettype none

package tpta_pkg;

   localparam int SLOTS      = 32;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int TAG_W      = 16;
   localparam int IDX_W      = 8;
   localparam int PERIOD_W   = 16;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_AUDIT_PERIOD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTING_MASTER = 1'd1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_COUNT  = 2'd2,
      CMD_AUDIT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_NEW       = 2'd0,
      PH_REPORTED  = 2'd1,
      PH_CONFIRMED = 2'd2,
      PH_GONE      = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_BAD_PHASE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_DRAIN,
      S_INSERT_WR,
      S_AUDIT_RD,
      S_AUDIT_EXEC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      phase_type           phase;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   last_seen;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic scan_rd;
      logic audit_rd;
      logic audit_exec;
      logic insert_wr;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    idx_bad;
      logic    scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/tag_presence_table_aging.sv @@
// Top level of the tag presence table with aging.
//
//   group  direction  tdata / data                       tuser / index
//   req_   in         tag, slot_index, beat, now (72 b)  command (2 b)
//   rsp_   out        slot, count, rep tag, phase (40 b) status, report_valid (3 b)
//   csr_   in         register value (16 b)              register index (1 b)
//
// One word at a time. From acceptance to rsp_tvalid, find and count go through
// decode, one slot read per cycle, drain and load, and insert adds its write before
// the load; audit goes through decode, read, age and load, a bad-index audit through
// decode and load. The next word is taken in the idle state.
// Reset marks all slots free at once through per-slot valid bits and holds req_tready
// and csr_ready low. A new word is taken while the previous result waits on rsp_tready;
// a held result stalls the next one only at its load step.
`timescale 1ns / 1ps
`default_nettype none

module tag_presence_table_aging
   import tpta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] tag_id, [23:16] slot_index, [39:24] beat_period, [71:40] now_seconds
   input  wire logic [71:0]           req_tdata,
   // [1:0] command
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] found_slot, [16:8] match_count, [32:17] report_tag, [34:33] report_phase
   output logic [39:0]                rsp_tdata,
   // [1:0] status, [2] report_valid
   output logic [2:0]                 rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type         dp_cmd;
   dp_status_type        dp_status;
   logic [1:0]           status;
   logic [IDX_W-1:0]     found_slot;
   logic [COUNT_W-1:0]   match_count;
   logic                 report_valid;
   logic [TAG_W-1:0]     report_tag;
   logic [1:0]           report_phase;

   assign csr_ready = !reset;

   tpta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   tpta_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_command      (req_tuser),
      .req_tag          (req_tdata[15:0]),
      .req_slot_index   (req_tdata[23:16]),
      .req_beat         (req_tdata[39:24]),
      .req_now          (req_tdata[71:40]),
      .rsp_status       (status),
      .rsp_found_slot   (found_slot),
      .rsp_match_count  (match_count),
      .rsp_report_valid (report_valid),
      .rsp_report_tag   (report_tag),
      .rsp_report_phase (report_phase)
   );

   assign rsp_tdata = {5'b0, report_phase, report_tag, match_count, found_slot};
   assign rsp_tuser = {report_valid, status};

endmodule

`default_nettype wire

@@ hw/rtl/tpta_ctrl.sv @@
// Sequencer for scan, insert and audit operations of the tag table.
`timescale 1ns / 1ps
`default_nettype none

module tpta_ctrl
   import tpta_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (dp_status.cmd == CMD_AUDIT) begin
               state_in = dp_status.idx_bad ? S_DONE : S_AUDIT_RD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = (dp_status.cmd == CMD_INSERT) ? S_INSERT_WR : S_DONE;
         end
         S_INSERT_WR:  state_in = S_DONE;
         S_AUDIT_RD:   state_in = S_AUDIT_EXEC;
         S_AUDIT_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd       = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready     = !reset;
            dp_cmd.capture = req_tvalid && !reset;
         end
         S_SCAN:       dp_cmd.scan_rd    = 1'b1;
         S_INSERT_WR:  dp_cmd.insert_wr  = 1'b1;
         S_AUDIT_RD:   dp_cmd.audit_rd   = 1'b1;
         S_AUDIT_EXEC: dp_cmd.audit_exec = 1'b1;
         S_DONE: begin
            if (rsp_free) begin
               dp_cmd.load_rsp = 1'b1;
               rsp_valid_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tpta_dp.sv @@
// Datapath: entry memory, valid bits, scan logic, audit aging and result registers.
`timescale 1ns / 1ps
`default_nettype none

module tpta_dp
   import tpta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          dp_cmd,
   output dp_status_type              dp_status,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [1:0]            req_command,
   input  wire logic [TAG_W-1:0]      req_tag,
   input  wire logic [IDX_W-1:0]      req_slot_index,
   input  wire logic [PERIOD_W-1:0]   req_beat,
   input  wire logic [TIME_W-1:0]     req_now,
   output logic [1:0]                 rsp_status,
   output logic [IDX_W-1:0]           rsp_found_slot,
   output logic [COUNT_W-1:0]         rsp_match_count,
   output logic                       rsp_report_valid,
   output logic [TAG_W-1:0]           rsp_report_tag,
   output logic [1:0]                 rsp_report_phase
);

   entry_type             entry_mem_ff [SLOTS];
   logic [SLOTS-1:0]      valid_ff;
   entry_type             rd_entry_ff;
   logic                  rd_valid_ff;
   entry_type             cur;

   cmd_type               cmd_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [PERIOD_W-1:0]   beat_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [PERIOD_W-1:0]   audit_period_ff;
   logic                  master_ff;

   logic [SLOT_W-1:0]     scan_ctr_ff;
   logic [SLOT_W-1:0]     eval_slot_ff;
   logic                  eval_ff;
   logic                  hit_ff;
   logic [SLOT_W-1:0]     hit_slot_ff;
   logic [CNT_W-1:0]      count_ff;

   logic                  aud_valid_ff;
   logic [TAG_W-1:0]      aud_tag_ff;
   phase_type             aud_phase_ff;

   logic                  idx_bad;
   logic [SLOT_W-1:0]     audit_slot;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  slot_match;

   logic [TIME_W-1:0]     elapsed;
   logic [TIME_W-1:0]     two_periods;
   logic [TIME_W-1:0]     four_periods;
   logic                  due;
   logic                  a_report;
   phase_type             a_rep_phase;
   logic                  a_update;
   logic                  a_free;
   phase_type             a_phase;

   logic                  mem_we;
   logic [SLOT_W-1:0]     wr_addr;
   entry_type             wr_data;

   assign idx_bad    = {1'b0, idx_ff} >= (IDX_W + 1)'(SLOTS);
   assign audit_slot = SLOT_W'(idx_ff);
   assign rd_addr    = dp_cmd.audit_rd ? audit_slot : scan_ctr_ff;
   assign cur        = rd_valid_ff ? rd_entry_ff : '0;

   assign dp_status.cmd       = cmd_ff;
   assign dp_status.idx_bad   = idx_bad;
   assign dp_status.scan_last = scan_ctr_ff == SLOT_W'(SLOTS - 1);

   always_comb begin
      if (cmd_ff == CMD_INSERT) begin
         slot_match = cur.tag == '0;
      end else if (tag_ff == '0) begin
         slot_match = cur.tag != '0;
      end else begin
         slot_match = cur.tag == tag_ff;
      end
   end

   assign elapsed      = now_ff - cur.last_seen;
   assign two_periods  = TIME_W'({cur.period, 1'b0});
   assign four_periods = TIME_W'({cur.period, 2'b00});
   assign due          = (cur.tag != '0) && (elapsed >= TIME_W'(audit_period_ff));

   always_comb begin
      a_report    = 1'b0;
      a_rep_phase = PH_NEW;
      a_update    = 1'b0;
      a_free      = 1'b0;
      a_phase     = cur.phase;
      if (due) begin
         case (cur.phase)
            PH_NEW: begin
               a_update = 1'b1;
               a_phase  = PH_REPORTED;
            end
            PH_GONE: begin
               if (elapsed > four_periods) begin
                  a_free = 1'b1;
               end else begin
                  a_report    = 1'b1;
                  a_rep_phase = PH_GONE;
                  a_free      = master_ff;
               end
            end
            PH_REPORTED, PH_CONFIRMED: begin
               if (elapsed > two_periods) begin
                  a_report    = 1'b1;
                  a_rep_phase = PH_GONE;
                  a_free      = master_ff;
                  a_update    = !master_ff;
                  a_phase     = PH_GONE;
               end else if (cur.phase == PH_REPORTED) begin
                  a_report    = 1'b1;
                  a_rep_phase = PH_REPORTED;
                  a_update    = master_ff;
                  a_phase     = PH_CONFIRMED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = audit_slot;
      wr_data = cur;
      if (dp_cmd.insert_wr) begin
         mem_we            = hit_ff;
         wr_addr           = hit_slot_ff;
         wr_data.tag       = tag_ff;
         wr_data.phase     = PH_NEW;
         wr_data.period    = beat_ff;
         wr_data.last_seen = now_ff;
      end else if (dp_cmd.audit_exec) begin
         mem_we            = a_update;
         wr_data.phase     = a_phase;
         wr_data.last_seen = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_entry_ff <= entry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (dp_cmd.audit_exec && a_free) begin
         valid_ff[audit_slot] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         audit_period_ff <= '0;
         master_ff       <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AUDIT_PERIOD:  audit_period_ff <= csr_data;
            CSR_ACTING_MASTER: master_ff       <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff  <= cmd_type'(req_command);
         tag_ff  <= req_tag;
         idx_ff  <= req_slot_index;
         beat_ff <= req_beat;
         now_ff  <= req_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= 1'b0;
      end else begin
         eval_ff <= dp_cmd.scan_rd;
      end
      eval_slot_ff <= scan_ctr_ff;
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         scan_ctr_ff  <= '0;
         hit_ff       <= 1'b0;
         hit_slot_ff  <= '0;
         count_ff     <= '0;
         aud_valid_ff <= 1'b0;
         aud_tag_ff   <= '0;
         aud_phase_ff <= PH_NEW;
      end else begin
         if (dp_cmd.scan_rd) begin
            scan_ctr_ff <= scan_ctr_ff + 1'b1;
         end
         if (eval_ff && slot_match) begin
            count_ff <= count_ff + 1'b1;
            if (!hit_ff) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= eval_slot_ff;
            end
         end
         if (dp_cmd.audit_exec) begin
            aud_valid_ff <= a_report;
            aud_tag_ff   <= a_report ? cur.tag : '0;
            aud_phase_ff <= a_rep_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_found_slot   <= '0;
         rsp_match_count  <= '0;
         rsp_report_valid <= 1'b0;
         rsp_report_tag   <= '0;
         rsp_report_phase <= PH_NEW;
         case (cmd_ff)
            CMD_INSERT, CMD_FIND: begin
               rsp_status     <= hit_ff ? ST_OK : ST_NOT_FOUND;
               rsp_found_slot <= hit_ff ? IDX_W'(hit_slot_ff) : '0;
            end
            CMD_COUNT: begin
               rsp_status      <= ST_OK;
               rsp_match_count <= COUNT_W'(count_ff);
            end
            CMD_AUDIT: begin
               rsp_status <= idx_bad ? ST_BAD_INDEX : ST_OK;
               if (!idx_bad) begin
                  rsp_report_valid <= aud_valid_ff;
                  rsp_report_tag   <= aud_tag_ff;
                  rsp_report_phase <= aud_phase_ff;
               end
            end
            default: rsp_status <= ST_BAD_PHASE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ test/tpta_checker.sv @@
// Checker for the tag presence table: predicts every result word and compares it.
`timescale 1ns / 1ps

module tpta_checker
   import tpta_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [71:0]           req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [39:0]           rsp_tdata,
   input  wire logic [2:0]            rsp_tuser,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         fail_count,
   output int                         pending,
   output int                         result_count,
   output int                         report_count,
   output int                         full_count,
   output int                         bad_index_count
);

   typedef struct {
      status_type         status;
      logic [7:0]         slot;
      logic [COUNT_W-1:0] hits;
      logic               rvalid;
      logic [TAG_W-1:0]   rtag;
      phase_type          rphase;
   } result_word_type;

   logic [TAG_W-1:0]    tag_tbl    [SLOTS];
   phase_type           phase_tbl  [SLOTS];
   logic [PERIOD_W-1:0] period_tbl [SLOTS];
   logic [TIME_W-1:0]   seen_tbl   [SLOTS];
   logic [15:0]         audit_period;
   logic                acting_master;

   result_word_type expected_results[$];

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (fail_count < 20)
         $display("mismatch on result %0d: %s got %0h want %0h", result_count, what, got,
                  want);
      fail_count++;
   endtask

   function automatic void clear_slot(input int s);
      tag_tbl[s]    = '0;
      phase_tbl[s]  = PH_NEW;
      period_tbl[s] = '0;
      seen_tbl[s]   = '0;
   endfunction

   function automatic bit slot_hit(input int s, input logic [TAG_W-1:0] tag);
      return (tag == 0) ? (tag_tbl[s] != 0) : (tag_tbl[s] == tag);
   endfunction

   function automatic result_word_type apply_tag_command(
      input cmd_type             cmd,
      input logic [TAG_W-1:0]    tag,
      input logic [IDX_W-1:0]    idx,
      input logic [PERIOD_W-1:0] beat,
      input logic [TIME_W-1:0]   now);
      result_word_type r;
      bit              done;
      logic [31:0]     elapsed;
      logic [31:0]     twice;
      logic [31:0]     quad;
      phase_type       ph;
      r.status = ST_OK;
      r.slot   = '0;
      r.hits   = '0;
      r.rvalid = 1'b0;
      r.rtag   = '0;
      r.rphase = PH_NEW;
      done     = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            r.status = ST_NOT_FOUND;
            for (int s = 0; s < SLOTS; s++) begin
               if (!done && tag_tbl[s] == 0) begin
                  tag_tbl[s]    = tag;
                  phase_tbl[s]  = PH_NEW;
                  period_tbl[s] = beat;
                  seen_tbl[s]   = now;
                  r.status      = ST_OK;
                  r.slot        = 8'(s);
                  done          = 1'b1;
               end
            end
         end
         CMD_FIND: begin
            r.status = ST_NOT_FOUND;
            for (int s = 0; s < SLOTS; s++) begin
               if (!done && slot_hit(s, tag)) begin
                  r.status = ST_OK;
                  r.slot   = 8'(s);
                  done     = 1'b1;
               end
            end
         end
         CMD_COUNT: begin
            for (int s = 0; s < SLOTS; s++)
               if (slot_hit(s, tag)) r.hits = r.hits + 1'b1;
         end
         default: begin
            if (idx >= SLOTS) begin
               r.status = ST_BAD_INDEX;
            end else if (tag_tbl[idx] != 0) begin
               elapsed = now - seen_tbl[idx];
               twice   = 32'(period_tbl[idx]) << 1;
               quad    = 32'(period_tbl[idx]) << 2;
               ph      = phase_tbl[idx];
               if (elapsed >= 32'(audit_period)) begin
                  if (ph == PH_NEW) begin
                     phase_tbl[idx] = PH_REPORTED;
                     seen_tbl[idx]  = now;
                  end else if (ph == PH_GONE) begin
                     if (elapsed > quad) begin
                        clear_slot(idx);
                     end else begin
                        r.rvalid = 1'b1;
                        r.rtag   = tag_tbl[idx];
                        r.rphase = PH_GONE;
                        if (acting_master) clear_slot(idx);
                     end
                  end else if (elapsed > twice) begin
                     phase_tbl[idx] = PH_GONE;
                     seen_tbl[idx]  = now;
                     r.rvalid       = 1'b1;
                     r.rtag         = tag_tbl[idx];
                     r.rphase       = PH_GONE;
                     if (acting_master) clear_slot(idx);
                  end else if (ph == PH_REPORTED) begin
                     r.rvalid = 1'b1;
                     r.rtag   = tag_tbl[idx];
                     r.rphase = PH_REPORTED;
                     if (acting_master) begin
                        phase_tbl[idx] = PH_CONFIRMED;
                        seen_tbl[idx]  = now;
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) clear_slot(s);
         audit_period    = '0;
         acting_master   = 1'b1;
         fail_count      = 0;
         result_count    = 0;
         report_count    = 0;
         full_count      = 0;
         bad_index_count = 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AUDIT_PERIOD:  audit_period  = csr_data;
               CSR_ACTING_MASTER: acting_master = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_tag_command(cmd_type'(req_tuser), req_tdata[15:0],
               req_tdata[23:16], req_tdata[39:24], req_tdata[71:40]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_tdata, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser[1:0] != want.status)
                  report_mismatch("status", rsp_tuser[1:0], want.status);
               if (rsp_tdata[7:0] != want.slot)
                  report_mismatch("found_slot", rsp_tdata[7:0], want.slot);
               if (rsp_tdata[16:8] != want.hits)
                  report_mismatch("match_count", rsp_tdata[16:8], want.hits);
               if (rsp_tuser[2] != want.rvalid)
                  report_mismatch("report_valid", rsp_tuser[2], want.rvalid);
               if (rsp_tdata[32:17] != want.rtag)
                  report_mismatch("report_tag", rsp_tdata[32:17], want.rtag);
               if (rsp_tdata[34:33] != want.rphase)
                  report_mismatch("report_phase", rsp_tdata[34:33], want.rphase);
               if (want.rvalid) report_count++;
               if (want.status == ST_BAD_INDEX) bad_index_count++;
               if (want.status == ST_NOT_FOUND && want.hits == 0 && want.slot == 0 &&
                   !want.rvalid)
                  full_count++;
            end
            result_count++;
         end
      end
      pending <= expected_results.size();
   end

endmodule

@@ test/tb.sv @@
// Top of the tag presence table test: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;
   import tpta_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [71:0]           req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int fail_count;
   int pending;
   int result_count;
   int report_count;
   int full_count;
   int bad_index_count;
   int setting_count = 0;
   bit calm = 1'b0;

   tag_presence_table_aging DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tpta_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .result_count    (result_count),
      .report_count    (report_count),
      .full_count      (full_count),
      .bad_index_count (bad_index_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input cmd_type cmd, input logic [15:0] tag, input logic [7:0] idx,
                            input logic [15:0] beat, input logic [31:0] now);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, beat, idx, tag};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   // drain all results, then write both registers
   task automatic write_settings(input logic [15:0] period, input logic master);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_AUDIT_PERIOD;
      csr_data  <= period;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ACTING_MASTER;
      csr_data  <= {15'($urandom), master};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   initial begin : rsp_stall
      int span;
      int gap;
      forever begin
         rsp_tready <= 1'b1;
         span = $urandom_range(1, 12);
         repeat (span) @(posedge clock);
         gap = calm ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [31:0] now_cur;
      logic [15:0] period;
      logic        master;
      logic [15:0] tag;
      logic [15:0] beat;
      logic [7:0]  idx;
      cmd_type     cmd;
      int          len;
      int          r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_settings(16'd0, 1'b1);
      send_word(CMD_FIND, 16'h0000, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_COUNT, 16'h0000, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_AUDIT, 16'($urandom), 8'd0, 16'($urandom), $urandom);
      send_word(CMD_AUDIT, 16'($urandom), 8'd255, 16'($urandom), $urandom);
      send_word(CMD_AUDIT, 16'($urandom), 8'(SLOTS), 16'($urandom), $urandom);
      send_word(CMD_INSERT, 16'hFFFF, 8'($urandom), 16'hFFFF, 32'hFFFF_FFF0);
      send_word(CMD_INSERT, 16'h0000, 8'($urandom), 16'd5, 32'h0000_1234);
      send_word(CMD_INSERT, 16'h0001, 8'($urandom), 16'd2, 32'hFFFF_FFF0);
      send_word(CMD_FIND, 16'hFFFF, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_FIND, 16'h0000, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_FIND, 16'h0001, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_FIND, 16'h0007, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_COUNT, 16'h0000, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_COUNT, 16'hFFFF, 8'($urandom), 16'($urandom), $urandom);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'hFFFF_FFF0);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'hFFFF_FFF2);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'hFFFF_FFF4);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'h0000_0002);

      write_settings(16'd0, 1'b0);
      send_word(CMD_INSERT, 16'h0002, 8'($urandom), 16'd3, 32'd100);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'd100);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'd102);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'd110);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'd112);
      send_word(CMD_AUDIT, 16'($urandom), 8'd1, 16'($urandom), 32'd200);
      send_word(CMD_AUDIT, 16'($urandom), 8'd0, 16'($urandom), 32'd200);

      now_cur = 32'hFFFF_F000;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin period = 16'd0;     master = 1'b1; len = 160; end
            1:       begin period = 16'd3;     master = 1'b0; len = 150; end
            2:       begin period = 16'hFFFF;  master = 1'b0; len = 120; end
            3:       begin period = 16'($urandom_range(1, 10)); master = 1'b1; len = 200; end
            default: begin period = 16'($urandom); master = 1'($urandom); len = 100; end
         endcase
         write_settings(period, master);
         for (int n = 0; n < len; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 70)      now_cur = now_cur + $urandom_range(0, 6);
            else if (r < 90) now_cur = now_cur + $urandom_range(7, 40);
            else if (r < 97) now_cur = now_cur + $urandom_range(0, 70000);
            else             now_cur = $urandom;
            r = $urandom_range(99);
            if (r < 60)      tag = 16'($urandom_range(1, 12));
            else if (r < 70) tag = 16'h0000;
            else             tag = 16'($urandom);
            r = $urandom_range(99);
            if (r < 85)      beat = 16'($urandom_range(1, 6));
            else if (r < 95) beat = 16'd0;
            else             beat = 16'($urandom);
            r = $urandom_range(99);
            if (r < 60)      idx = 8'($urandom_range(0, 7));
            else if (r < 90) idx = 8'($urandom_range(0, SLOTS - 1));
            else             idx = 8'($urandom);
            r = $urandom_range(99);
            if (r < 28)      cmd = CMD_INSERT;
            else if (r < 40) cmd = CMD_FIND;
            else if (r < 50) cmd = CMD_COUNT;
            else             cmd = CMD_AUDIT;
            if (cmd == CMD_INSERT && tag == 0 && $urandom_range(1) == 0) tag = 16'd1;
            send_word(cmd, tag, idx, beat, now_cur);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
      $display("checked %0d result words: %0d tag reports, %0d misses or full-table inserts,",
               result_count, report_count, full_count);
      $display("%0d bad slot indexes, over %0d register settings", bad_index_count,
               setting_count);
      if (fail_count == 0)
         $display("tag_presence_table_aging test passed");
      else
         $display("tag_presence_table_aging test failed");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tag_presence_table_aging test failed");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/tpta_pkg.sv
hw/rtl/tpta_ctrl.sv
hw/rtl/tpta_dp.sv
hw/rtl/tag_presence_table_aging.sv
test/tpta_checker.sv
test/tb.sv
